// ===== src/utf8sd_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Shared types and constants of the UTF-8 stream decoder: byte classes,
// result status codes, item layouts and the scalar range limits.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned CpWidth    = 21;

  // Byte classes produced by the front end
  typedef enum logic [2:0] {
    CLS_ASCII = 3'd0,
    CLS_LEAD2 = 3'd1,
    CLS_LEAD3 = 3'd2,
    CLS_LEAD4 = 3'd3,
    CLS_CONT  = 3'd4,
    CLS_BAD   = 3'd5
  } cls_e;

  typedef enum logic [1:0] {
    ST_PENDING = 2'd0,
    ST_DONE    = 2'd1,
    ST_ERROR   = 2'd2
  } status_e;

  // Classified byte: class plus the payload bits that the class carries
  typedef struct packed {
    cls_e       cls;
    logic [6:0] bits;
  } cls_item_t;

  typedef struct packed {
    status_e              status;
    logic [CpWidth-1:0]   code_point;
  } result_t;

  localparam logic [2:0] Len2 = 3'd2;
  localparam logic [2:0] Len3 = 3'd3;
  localparam logic [2:0] Len4 = 3'd4;

  localparam logic [CpWidth-1:0] MaxScalar = 21'h10FFFF;
  localparam logic [CpWidth-1:0] SurrLo    = 21'h00D800;
  localparam logic [CpWidth-1:0] SurrHi    = 21'h00DFFF;
  localparam logic [CpWidth-1:0] Min2      = 21'h000080;
  localparam logic [CpWidth-1:0] Min3      = 21'h000800;
  localparam logic [CpWidth-1:0] Min4      = 21'h010000;

endpackage

// ===== src/utf8sd_fifo.sv =====
// ----------------------------------------------------------------------------
// utf8sd_fifo
// Small register queue with full/empty flags, used between decoder stages
// and in front of the result ports.
// ----------------------------------------------------------------------------
module utf8sd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = utf8sd_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== src/utf8sd_front.sv =====
// ----------------------------------------------------------------------------
// utf8sd_front
// Accepts raw bytes, classifies each one (ASCII, lead byte, continuation,
// invalid) and queues the class with its payload bits for the back end.
// ----------------------------------------------------------------------------
module utf8sd_front #(
  parameter int unsigned QueueDepth = utf8sd_pkg::QueueDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [7:0]            in_byte_i,
  output logic                  full_o,
  input  logic                  item_pop_i,
  output utf8sd_pkg::cls_item_t item_o,
  output logic                  item_empty_o
);

  utf8sd_pkg::cls_item_t item;
  logic [$bits(utf8sd_pkg::cls_item_t)-1:0] item_raw;

  always_comb begin
    unique casez (in_byte_i)
      8'b0???????: begin
        item.cls  = utf8sd_pkg::CLS_ASCII;
        item.bits = in_byte_i[6:0];
      end
      8'b10??????: begin
        item.cls  = utf8sd_pkg::CLS_CONT;
        item.bits = {1'b0, in_byte_i[5:0]};
      end
      8'b110?????: begin
        item.cls  = utf8sd_pkg::CLS_LEAD2;
        item.bits = {2'b0, in_byte_i[4:0]};
      end
      8'b1110????: begin
        item.cls  = utf8sd_pkg::CLS_LEAD3;
        item.bits = {3'b0, in_byte_i[3:0]};
      end
      8'b11110???: begin
        item.cls  = utf8sd_pkg::CLS_LEAD4;
        item.bits = {4'b0, in_byte_i[2:0]};
      end
      default: begin
        item.cls  = utf8sd_pkg::CLS_BAD;
        item.bits = '0;
      end
    endcase
  end

  utf8sd_fifo #(
    .Width($bits(utf8sd_pkg::cls_item_t)),
    .Depth(QueueDepth)
  ) u_cls_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (item),
    .full_o (full_o),
    .pop_i  (item_pop_i),
    .data_o (item_raw),
    .empty_o(item_empty_o)
  );

  assign item_o = utf8sd_pkg::cls_item_t'(item_raw);

endmodule

// ===== src/utf8sd_back.sv =====
// ----------------------------------------------------------------------------
// utf8sd_back
// Sequence tracker: holds the partial code point and byte counts, takes one
// classified byte per cycle unless res_full_i, emits pending, done or error.
// ----------------------------------------------------------------------------
module utf8sd_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  utf8sd_pkg::cls_item_t item_i,
  input  logic                  item_empty_i,
  output logic                  item_pop_o,
  input  logic                  res_full_i,
  output logic                  res_push_o,
  output utf8sd_pkg::result_t   res_o
);

  localparam int unsigned CpW = utf8sd_pkg::CpWidth;

  logic [CpW-1:0] partial_q, partial_d;
  logic [2:0]     expected_q, expected_d;
  logic [2:0]     seen_q, seen_d;
  logic           fire;
  logic [CpW-1:0] shifted;
  logic [2:0]     seen_inc;
  logic [CpW-1:0] min_val;
  logic           scalar_ok;

  assign fire       = !item_empty_i && !res_full_i;
  assign item_pop_o = fire;
  assign res_push_o = fire;

  assign shifted  = {partial_q[CpW-7:0], item_i.bits[5:0]};
  assign seen_inc = seen_q + 3'd1;

  always_comb begin
    case (expected_q)
      utf8sd_pkg::Len2: min_val = utf8sd_pkg::Min2;
      utf8sd_pkg::Len3: min_val = utf8sd_pkg::Min3;
      default:          min_val = utf8sd_pkg::Min4;
    endcase
  end

  assign scalar_ok = (shifted >= min_val) && (shifted <= utf8sd_pkg::MaxScalar) &&
                     !((shifted >= utf8sd_pkg::SurrLo) && (shifted <= utf8sd_pkg::SurrHi));

  always_comb begin
    partial_d         = partial_q;
    expected_d        = expected_q;
    seen_d            = seen_q;
    res_o.status      = utf8sd_pkg::ST_PENDING;
    res_o.code_point  = '0;
    if (expected_q == 3'd0) begin
      unique case (item_i.cls)
        utf8sd_pkg::CLS_ASCII: begin
          res_o.status     = utf8sd_pkg::ST_DONE;
          res_o.code_point = {{(CpW-7){1'b0}}, item_i.bits};
        end
        utf8sd_pkg::CLS_LEAD2: begin
          partial_d  = {{(CpW-7){1'b0}}, item_i.bits};
          expected_d = utf8sd_pkg::Len2;
          seen_d     = 3'd1;
        end
        utf8sd_pkg::CLS_LEAD3: begin
          partial_d  = {{(CpW-7){1'b0}}, item_i.bits};
          expected_d = utf8sd_pkg::Len3;
          seen_d     = 3'd1;
        end
        utf8sd_pkg::CLS_LEAD4: begin
          partial_d  = {{(CpW-7){1'b0}}, item_i.bits};
          expected_d = utf8sd_pkg::Len4;
          seen_d     = 3'd1;
        end
        default: begin
          // stray byte while idle: flag it, keep state
          res_o.status = utf8sd_pkg::ST_ERROR;
        end
      endcase
    end else if (item_i.cls != utf8sd_pkg::CLS_CONT) begin
      // broken sequence: drop the byte and return to idle
      partial_d    = '0;
      expected_d   = '0;
      seen_d       = '0;
      res_o.status = utf8sd_pkg::ST_ERROR;
    end else if (seen_inc >= expected_q) begin
      partial_d  = '0;
      expected_d = '0;
      seen_d     = '0;
      if (scalar_ok) begin
        res_o.status     = utf8sd_pkg::ST_DONE;
        res_o.code_point = shifted;
      end else begin
        res_o.status = utf8sd_pkg::ST_ERROR;
      end
    end else begin
      partial_d = shifted;
      seen_d    = seen_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q  <= '0;
      expected_q <= '0;
      seen_q     <= '0;
    end else if (fire) begin
      partial_q  <= partial_d;
      expected_q <= expected_d;
      seen_q     <= seen_d;
    end
  end

endmodule

// ===== src/utf8_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Validating UTF-8 decoder, one byte in and one result out per item.
// ----------------------------------------------------------------------------
// Takes one byte per clock while full is low and returns one result per
// byte: pending, a completed code point, or a malformed-input error (code
// point reads zero unless complete). Throughput is one byte per cycle while
// the result queue has room; the shift-and-check in the sequence tracker is
// combinational. Each byte passes through the classifier queue and then the
// result queue before its result is visible on the output. Small queues sit
// between the byte classifier, the tracker and the result ports, so a stall
// on either side is buffered until a queue fills, then the other side stops.
module utf8_stream_decoder #(
  parameter int unsigned QueueDepth = utf8sd_pkg::QueueDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  input  logic [7:0]                        in_byte_i,
  output logic                              full,
  input  logic                              pop,
  output logic                              empty,
  output logic [1:0]                        status_o,
  output logic [utf8sd_pkg::CpWidth-1:0]    code_point_o
);

  utf8sd_pkg::cls_item_t item;
  logic                  item_empty;
  logic                  item_pop;
  logic                  res_full;
  logic                  res_push;
  utf8sd_pkg::result_t   res;
  utf8sd_pkg::result_t   res_head;
  logic [$bits(utf8sd_pkg::result_t)-1:0] res_raw;

  utf8sd_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .in_byte_i   (in_byte_i),
    .full_o      (full),
    .item_pop_i  (item_pop),
    .item_o      (item),
    .item_empty_o(item_empty)
  );

  utf8sd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .item_empty_i(item_empty),
    .item_pop_o  (item_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  utf8sd_fifo #(
    .Width($bits(utf8sd_pkg::result_t)),
    .Depth(QueueDepth)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_raw),
    .empty_o(empty)
  );

  assign res_head     = utf8sd_pkg::result_t'(res_raw);
  assign status_o     = res_head.status;
  assign code_point_o = res_head.code_point;

endmodule
